@@ rtl/core/sawt_pkg.sv @@
// ----------------------------------------------------------------------------
// sawt_pkg: shared types and constants for the sequence/ack window tracker
// Request and result layouts, status codes and the fixed header limits.
// ----------------------------------------------------------------------------
package sawt_pkg;

    localparam logic [15:0] HEADER_BYTES = 16'd20;
    localparam logic [15:0] PAYLOAD_MAX  = 16'd1024;
    // One less than half of the sequence space; sequence numbers wrap modulo 2^32.
    localparam logic [31:0] SEQ_HALF     = 32'h7FFF_FFFF;

    localparam logic FUNC_SEND = 1'b0;
    localparam logic FUNC_RECV = 1'b1;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_PID   = 2'd2,
        ST_TOO_LARGE = 2'd3
    } t_status;

    typedef struct packed {
        logic        func;
        logic [15:0] length;
        logic [31:0] rx_protocol_id;
        logic [31:0] rx_sequence;
        logic [31:0] rx_ack;
        logic [31:0] rx_ack_bitmap;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] tx_sequence;
        logic [31:0] tx_ack;
        logic [31:0] tx_ack_bitmap;
        logic [15:0] payload_length;
        logic [31:0] local_ack_bitmap;
    } t_out_item;

endpackage

@@ rtl/core/sequence_ack_window_tracker_core.sv @@
// ----------------------------------------------------------------------------
// sequence_ack_window_tracker_core: reliable-datagram header engine
// Builds send headers and processes received headers against the local and
// remote sequence/ack windows.
//
//   channel | signals                          | direction
//   --------+----------------------------------+----------
//   in      | i_in_valid, o_in_stall, i_in     | request
//   out     | o_out_valid, i_out_stall, o_out  | result
//   cfg     | i_cfg_we, i_cfg_wdata            | protocol id write
//
// One request per cycle while results are not stalled; a request passes the
// request register, then the header logic, then the result register.
// Synchronous active-low reset clears sequences, windows and protocol id.
// A stalled result holds the result register; the request register keeps
// taking a request as long as its content can move on in the same cycle.
// ----------------------------------------------------------------------------
module sequence_ack_window_tracker_core #(
    parameter int ACK_WINDOW = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  sawt_pkg::t_in_item  i_in,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output sawt_pkg::t_out_item o_out,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);

    logic                r_in_valid;
    sawt_pkg::t_in_item  r_in;
    logic                r_out_valid;
    sawt_pkg::t_out_item r_out;
    logic [31:0]         r_protocol_id;

    logic                out_free;
    logic                fire;
    logic                in_take;
    sawt_pkg::t_out_item result;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    sawt_hdr_engine #(
        .ACK_WINDOW(ACK_WINDOW)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in),
        .i_protocol_id(r_protocol_id),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_protocol_id <= '0;
        end else begin
            if (i_cfg_we) begin
                r_protocol_id <= i_cfg_wdata;
            end
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_stall_needs_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid && i_out_stall))
        else $error("request stalled with no pending work");

    a_pending_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && out_free) |=> o_out_valid)
        else $error("pending request did not reach result register");

    a_reject_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.status != sawt_pkg::ST_OK)
        |-> (o_out.tx_sequence == 32'd0 && o_out.tx_ack == 32'd0
             && o_out.tx_ack_bitmap == 32'd0 && o_out.payload_length == 16'd0))
        else $error("rejected result carries header fields");

endmodule

@@ rtl/core/sawt_hdr_engine.sv @@
// ----------------------------------------------------------------------------
// sawt_hdr_engine: sequence state and single-pass header logic
// Holds local/remote sequence numbers and both ack windows; builds the
// result for one request and commits the new state when i_fire is high.
// ----------------------------------------------------------------------------
module sawt_hdr_engine #(
    parameter int ACK_WINDOW = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_fire,
    input  sawt_pkg::t_in_item   i_item,
    input  logic [31:0]          i_protocol_id,
    output sawt_pkg::t_out_item  o_result
);

    localparam int IDX_W = $clog2(ACK_WINDOW);

    logic [31:0]           r_local_seq,  n_local_seq;
    logic [31:0]           r_remote_seq, n_remote_seq;
    logic [ACK_WINDOW-1:0] r_local_win,  n_local_win;
    logic [ACK_WINDOW-1:0] r_remote_win, n_remote_win;

    logic [31:0]           seq_fwd;
    logic [31:0]           seq_bwd;
    logic [31:0]           ack_dist;
    logic                  more_recent;
    logic [31:0]           peer_shifted;
    logic [ACK_WINDOW-1:0] old_bit;
    logic                  ok;

    assign seq_fwd  = i_item.rx_sequence - r_remote_seq;
    assign seq_bwd  = r_remote_seq - i_item.rx_sequence;
    assign ack_dist = r_local_seq - i_item.rx_ack;

    // Wrap-aware "newer than": a tie at exactly half the space favors the
    // numerically smaller incoming sequence.
    assign more_recent = ((i_item.rx_sequence > r_remote_seq) && (seq_fwd <= sawt_pkg::SEQ_HALF))
                      || ((r_remote_seq > i_item.rx_sequence) && (seq_bwd > sawt_pkg::SEQ_HALF));

    assign peer_shifted = i_item.rx_ack_bitmap << ack_dist[IDX_W-1:0];
    assign old_bit      = {{(ACK_WINDOW-1){1'b0}}, 1'b1} << seq_bwd[IDX_W-1:0];

    always_comb begin
        n_local_seq  = r_local_seq;
        n_remote_seq = r_remote_seq;
        n_local_win  = r_local_win;
        n_remote_win = r_remote_win;
        o_result     = '0;
        o_result.status = sawt_pkg::ST_OK;

        if (i_item.func == sawt_pkg::FUNC_SEND) begin
            if (i_item.length > sawt_pkg::PAYLOAD_MAX) begin
                o_result.status = sawt_pkg::ST_TOO_LARGE;
            end else begin
                o_result.tx_sequence   = r_local_seq;
                o_result.tx_ack        = r_remote_seq;
                o_result.tx_ack_bitmap = 32'(r_remote_win);
                n_local_win = {r_local_win[ACK_WINDOW-2:0], 1'b0};
                n_local_seq = r_local_seq + 32'd1;
            end
        end else if (i_item.length <= sawt_pkg::HEADER_BYTES) begin
            o_result.status = sawt_pkg::ST_SHORT;
        end else if (i_item.rx_protocol_id != i_protocol_id) begin
            o_result.status = sawt_pkg::ST_BAD_PID;
        end else begin
            o_result.payload_length = i_item.length - sawt_pkg::HEADER_BYTES;
            if (more_recent) begin
                n_remote_seq = i_item.rx_sequence;
                n_remote_win = {r_remote_win[ACK_WINDOW-2:0], 1'b1};
            end else if (seq_bwd < 32'(ACK_WINDOW)) begin
                n_remote_win = r_remote_win | old_bit;
            end
            if (ack_dist < 32'(ACK_WINDOW)) begin
                n_local_win = r_local_win | peer_shifted[ACK_WINDOW-1:0];
            end
        end

        o_result.local_ack_bitmap = 32'(n_local_win);
    end

    assign ok = (o_result.status == sawt_pkg::ST_OK);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_seq  <= '0;
            r_remote_seq <= '0;
            r_local_win  <= '0;
            r_remote_win <= '0;
        end else if (i_fire) begin
            r_local_seq  <= n_local_seq;
            r_remote_seq <= n_remote_seq;
            r_local_win  <= n_local_win;
            r_remote_win <= n_remote_win;
        end
    end

    a_send_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && ok && i_item.func == sawt_pkg::FUNC_SEND)
        |=> (r_local_seq == $past(r_local_seq) + 32'd1))
        else $error("local sequence did not advance on send");

    a_send_ages_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && ok && i_item.func == sawt_pkg::FUNC_SEND) |=> !r_local_win[0])
        else $error("local ack window not aged on send");

    a_reject_holds_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !ok) |=> ($stable(r_local_seq) && $stable(r_remote_seq)
                             && $stable(r_local_win) && $stable(r_remote_win)))
        else $error("state changed on rejected request");

endmodule
